// File: src/multi_stopwatch_with_skew_reset_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stopwatch table
// Shared immediate-style wrappers around concurrent assertions, clocked on
// i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_STOPWATCH_WITH_SKEW_RESET_CORE_DEFINES_SVH
`define MULTI_STOPWATCH_WITH_SKEW_RESET_CORE_DEFINES_SVH

// Same-cycle implication.
`define MSW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("msw assertion failed");

// Next-cycle implication.
`define MSW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("msw assertion failed");

`endif

// File: src/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg
// Constants, codes and types of the stopwatch table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msw_pkg;

    localparam int NUM_CLOCKS = 16;
    localparam int ADDR_W     = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_CLOCKS + 1);

    localparam int TIME_W = 32;
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET_ONE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESET_ALL = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNALLOC = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    // Register index, taken from paddr[2].
    localparam logic REG_MAX_SKEW = 1'b0;

    localparam logic [TIME_W-1:0] ELAPSED_MAX     = 32'h7FFF_FFFF;
    localparam logic [TIME_W-1:0] ELAPSED_INVALID = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] MAX_SKEW_RST    = 32'd3600;

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// File: src/msw_req_if.sv
// ----------------------------------------------------------------------------
// msw_req_if
// Request channel of the stopwatch table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msw_req_if;
    import msw_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_sec;
    logic [IDX_W-1:0]  clock_index;
    logic              restart_after_read;

    modport source (
        output valid, req_type, now_sec, clock_index, restart_after_read,
        input  ready
    );

    modport sink (
        input  valid, req_type, now_sec, clock_index, restart_after_read,
        output ready
    );
endinterface

// File: src/msw_rsp_if.sv
// ----------------------------------------------------------------------------
// msw_rsp_if
// Response channel of the stopwatch table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface msw_rsp_if;
    import msw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         new_index;
    logic signed [TIME_W-1:0] elapsed_sec;
    logic [STAT_W-1:0]        status;
    logic                     skew_reset_done;

    modport source (
        output valid, new_index, elapsed_sec, status, skew_reset_done,
        input  ready
    );

    modport sink (
        input  valid, new_index, elapsed_sec, status, skew_reset_done,
        output ready
    );
endinterface

// File: src/multi_stopwatch_with_skew_reset_core.sv
// A request is captured on acceptance, its start time is read from memory and
// the response is registered when the update state completes. A new request is
// taken only in the idle state, after the update and write-back of the last one.
// A response waiting on the output stalls the update state until it is taken.
// Reset (synchronous, active low) clears the count, last time, skew limit
// (to 3600) and the restart marks at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_stopwatch_with_skew_reset_core
// Table of stopwatch start times with allocation, elapsed queries, single
// and global restarts, and a guard that restarts all clocks on time skew.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_stopwatch_with_skew_reset_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    msw_req_if.sink                            i_req,
    msw_rsp_if.source                          o_rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [msw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [msw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import msw_pkg::*;

    // Start-time memory.
    t_time             mem [NUM_CLOCKS];
    t_time             r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    // A set mark means the entry was restarted by a global restart and its
    // start time is r_all_time rather than the memory contents.
    logic [NUM_CLOCKS-1:0] r_stale, n_stale;
    t_time                 r_all_time, n_all_time;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_in_use, n_in_use;
    t_time             r_last, n_last;
    logic              r_seen, n_seen;
    t_time             r_max_skew;

    // Captured request.
    logic [REQ_W-1:0]  r_req_type;
    t_time             r_now;
    logic [IDX_W-1:0]  r_idx;
    logic              r_restart;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_index, n_out_index;
    t_time             r_out_elapsed, n_out_elapsed;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic              r_out_skew, n_out_skew;

    logic              accept;
    logic              fire;
    logic              idx_valid;
    logic              skew;
    t_time             last_eff;
    t_time             start_eff;
    t_time             since_last;
    t_time             since_start;
    logic [ADDR_W-1:0] idx_addr;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_SKEW) ? r_max_skew : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_skew <= MAX_SKEW_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_SKEW)) begin
            r_max_skew <= pwdata;
        end
    end

    assign accept        = i_req.valid && i_req.ready;
    assign i_req.ready   = (r_state == ST_IDLE);
    assign fire          = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    assign idx_addr    = ADDR_W'(r_idx);
    assign idx_valid   = (CNT_W'(r_idx) < r_in_use) && (32'(r_idx) < NUM_CLOCKS);
    assign last_eff    = r_seen ? r_last : r_now;
    assign since_last  = r_now - last_eff;
    assign skew        = (r_now < last_eff) || (since_last > r_max_skew);
    assign start_eff   = r_stale[idx_addr] ? r_all_time : r_rd_data;
    assign since_start = r_now - start_eff;

    // Keep the read address on the held request while in the update state
    // so that a stall sees current data.
    assign rd_addr = (r_state == ST_IDLE) ? ADDR_W'(i_req.clock_index) : idx_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_now;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state       = r_state;
        n_in_use      = r_in_use;
        n_last        = r_last;
        n_seen        = r_seen;
        n_stale       = r_stale;
        n_all_time    = r_all_time;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_index   = r_out_index;
        n_out_elapsed = r_out_elapsed;
        n_out_status  = r_out_status;
        n_out_skew    = r_out_skew;
        wr_en         = 1'b0;
        wr_addr       = idx_addr;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state       = ST_IDLE;
                    n_seen        = 1'b1;
                    n_last        = last_eff;
                    n_out_valid   = 1'b1;
                    n_out_index   = '0;
                    n_out_elapsed = '0;
                    n_out_status  = STAT_OK;
                    n_out_skew    = 1'b0;
                    case (r_req_type)
                        REQ_ALLOC: begin
                            if (r_in_use < CNT_W'(NUM_CLOCKS)) begin
                                wr_en            = 1'b1;
                                wr_addr          = ADDR_W'(r_in_use);
                                n_stale[wr_addr] = 1'b0;
                                n_out_index      = IDX_W'(r_in_use);
                                n_in_use         = r_in_use + 1'b1;
                            end else begin
                                n_out_status = STAT_FULL;
                            end
                        end
                        REQ_QUERY: begin
                            n_last = r_now;
                            if (skew) begin
                                n_stale    = '1;
                                n_all_time = r_now;
                                n_out_skew = 1'b1;
                            end
                            if (idx_valid) begin
                                // After a skew restart the entry starts now.
                                if (skew || (r_now < start_eff)) begin
                                    n_out_elapsed = '0;
                                end else if (since_start[TIME_W-1]) begin
                                    n_out_elapsed = ELAPSED_MAX;
                                end else begin
                                    n_out_elapsed = since_start;
                                end
                                if (r_restart) begin
                                    wr_en             = 1'b1;
                                    n_stale[idx_addr] = 1'b0;
                                end
                            end else begin
                                n_out_elapsed = ELAPSED_INVALID;
                                n_out_status  = STAT_UNALLOC;
                            end
                        end
                        REQ_RESET_ONE: begin
                            if (idx_valid) begin
                                wr_en             = 1'b1;
                                n_stale[idx_addr] = 1'b0;
                            end else begin
                                n_out_status = STAT_UNALLOC;
                            end
                        end
                        REQ_RESET_ALL: begin
                            n_stale    = '1;
                            n_all_time = r_now;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_use    <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_stale     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_all_time    <= n_all_time;
        r_out_index   <= n_out_index;
        r_out_elapsed <= n_out_elapsed;
        r_out_status  <= n_out_status;
        r_out_skew    <= n_out_skew;
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_now      <= i_req.now_sec;
            r_idx      <= i_req.clock_index;
            r_restart  <= i_req.restart_after_read;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.new_index       = r_out_index;
    assign o_rsp.elapsed_sec     = $signed(r_out_elapsed);
    assign o_rsp.status          = r_out_status;
    assign o_rsp.skew_reset_done = r_out_skew;

endmodule

// File: src/msw_checker.sv
// ----------------------------------------------------------------------------
// msw_checker
// Port-level checks of the stopwatch table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_stopwatch_with_skew_reset_core_defines.svh"

module msw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [msw_pkg::IDX_W-1:0]         i_new_index,
    input logic signed [msw_pkg::TIME_W-1:0] i_elapsed_sec,
    input logic [msw_pkg::STAT_W-1:0]        i_status,
    input logic                              i_skew_reset_done
);
    import msw_pkg::*;

    // Requests are handled one at a time.
    `MSW_ASSERT_NXT(a_one_at_a_time, i_req_valid && i_req_ready, !i_req_ready)

    // A stalled response keeps its contents.
    `MSW_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_new_index) && $stable(i_elapsed_sec) && $stable(i_status) && $stable(i_skew_reset_done))

    // A full table reports nothing else.
    `MSW_ASSERT_IMP(a_full_clean, i_rsp_valid && (i_status == STAT_FULL), (i_new_index == '0) && (i_elapsed_sec == '0) && !i_skew_reset_done)

    // The only negative elapsed value marks an unallocated clock.
    `MSW_ASSERT_IMP(a_neg_invalid, i_rsp_valid && i_elapsed_sec[TIME_W-1], (i_elapsed_sec == $signed(ELAPSED_INVALID)) && (i_status == STAT_UNALLOC))

endmodule

bind multi_stopwatch_with_skew_reset_core msw_checker u_msw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_new_index       (o_rsp.new_index),
    .i_elapsed_sec     (o_rsp.elapsed_sec),
    .i_status          (o_rsp.status),
    .i_skew_reset_done (o_rsp.skew_reset_done)
);
